>>> rtl/fw3_pkg.sv
package fw3_pkg;

  localparam int GRID_MAX   = 16;
  localparam int GRID_RESET = 16;
  localparam int COORD_W    = 5;
  localparam int WALK_W     = COORD_W + 1;
  localparam int IDX_W      = $clog2(GRID_MAX);
  localparam int ADDR_W     = 3 * IDX_W;
  localparam int DEPTH      = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int NODE_W     = 13;
  localparam int OUT_W      = 14;
  localparam int PFX_W      = 3;

  localparam logic CMD_MARK  = 1'b0;
  localparam logic CMD_COUNT = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PSETUP,
    S_PREAD,
    S_PACC,
    S_DELTA,
    S_UREAD,
    S_UWRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [NODE_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic             sub;
    logic [OUT_W-1:0] a;
    logic [OUT_W-1:0] b;
  } alu_req_t;

endpackage

>>> rtl/fw3_ram.sv
module fw3_ram (
  input  logic                         clk_i,
  input  fw3_pkg::ram_req_t            req_i,
  output logic [fw3_pkg::NODE_W-1:0]   rdata_o
);

  logic [fw3_pkg::NODE_W-1:0] mem [fw3_pkg::DEPTH];
  logic [fw3_pkg::NODE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fw3_alu.sv
module fw3_alu (
  input  fw3_pkg::alu_req_t           req_i,
  output logic [fw3_pkg::OUT_W-1:0]   res_o
);

  // Wraps modulo 2^OUT_W; callers take the low bits they need.
  always_comb begin
    if (req_i.sub) begin
      res_o = req_i.a - req_i.b;
    end else begin
      res_o = req_i.a + req_i.b;
    end
  end

endmodule

>>> rtl/fw3_ctrl.sv
module fw3_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [fw3_pkg::COORD_W-1:0]   low_x_i,
  input  logic [fw3_pkg::COORD_W-1:0]   low_y_i,
  input  logic [fw3_pkg::COORD_W-1:0]   low_z_i,
  input  logic [fw3_pkg::COORD_W-1:0]   high_x_i,
  input  logic [fw3_pkg::COORD_W-1:0]   high_y_i,
  input  logic [fw3_pkg::COORD_W-1:0]   high_z_i,
  input  logic [fw3_pkg::COORD_W-1:0]   grid_i,
  output fw3_pkg::ram_req_t             ram_req_o,
  input  logic [fw3_pkg::NODE_W-1:0]    ram_rdata_i,
  output fw3_pkg::alu_req_t             alu_req_o,
  input  logic [fw3_pkg::OUT_W-1:0]     alu_res_i,
  output logic                          res_valid_o,
  output logic [fw3_pkg::OUT_W-1:0]     res_data_o,
  input  logic                          res_free_i
);

  localparam int CW = fw3_pkg::COORD_W;
  localparam int WW = fw3_pkg::WALK_W;

  function automatic logic [CW-1:0] clamp_hi(input logic [CW-1:0] c, input logic [CW-1:0] g);
    clamp_hi = (c > g) ? g : c;
  endfunction

  // Lower corner minus one; a zero corner gives an empty prefix.
  function automatic logic [CW-1:0] clamp_lo(input logic [CW-1:0] c, input logic [CW-1:0] g);
    logic [CW-1:0] m;
    m = c - CW'(1);
    clamp_lo = (c == '0) ? '0 : ((m > g) ? g : m);
  endfunction

  function automatic logic [fw3_pkg::ADDR_W-1:0] node_addr(input logic [CW-1:0] x,
                                                            input logic [CW-1:0] y,
                                                            input logic [CW-1:0] z);
    logic [CW-1:0] xm;
    logic [CW-1:0] ym;
    logic [CW-1:0] zm;
    xm = x - CW'(1);
    ym = y - CW'(1);
    zm = z - CW'(1);
    node_addr = {xm[fw3_pkg::IDX_W-1:0], ym[fw3_pkg::IDX_W-1:0], zm[fw3_pkg::IDX_W-1:0]};
  endfunction

  function automatic logic [fw3_pkg::OUT_W-1:0] sext(input logic [fw3_pkg::NODE_W-1:0] v);
    sext = {{(fw3_pkg::OUT_W - fw3_pkg::NODE_W){v[fw3_pkg::NODE_W-1]}}, v};
  endfunction

  fw3_pkg::state_e state_q, state_d;
  logic                          cmd_q, cmd_d;
  logic [CW-1:0]                 lo_x_q, lo_y_q, lo_z_q, lo_x_d, lo_y_d, lo_z_d;
  logic [CW-1:0]                 hi_x_q, hi_y_q, hi_z_q, hi_x_d, hi_y_d, hi_z_d;
  logic [CW-1:0]                 cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
  logic [CW-1:0]                 x_q, y_q, z_q, x_d, y_d, z_d;
  logic [WW-1:0]                 ux_q, uy_q, uz_q, ux_d, uy_d, uz_d;
  logic [fw3_pkg::PFX_W-1:0]     k_q, k_d;
  logic [fw3_pkg::OUT_W-1:0]     acc_q, acc_d;
  logic [fw3_pkg::NODE_W-1:0]    delta_q, delta_d;
  logic [fw3_pkg::ADDR_W-1:0]    clr_q, clr_d;

  logic          mark_ok;
  logic          last_k;
  logic [CW-1:0] px, py, pz;
  logic [CW-1:0] nx, ny, nz;
  logic [WW-1:0] ax, ay, az;
  logic [WW-1:0] g_w;

  assign g_w    = WW'(grid_i);
  assign last_k = (k_q == '1);
  assign mark_ok = (low_x_i != '0) && (low_x_i <= grid_i) &&
                   (low_y_i != '0) && (low_y_i <= grid_i) &&
                   (low_z_i != '0) && (low_z_i <= grid_i);

  // Bit 0 of the prefix index picks the lower x, bit 1 y, bit 2 z.
  assign px = k_q[0] ? clamp_lo(lo_x_q, grid_i) : clamp_hi(hi_x_q, grid_i);
  assign py = k_q[1] ? clamp_lo(lo_y_q, grid_i) : clamp_hi(hi_y_q, grid_i);
  assign pz = k_q[2] ? clamp_lo(lo_z_q, grid_i) : clamp_hi(hi_z_q, grid_i);

  // Query walk: drop the lowest set bit.
  assign nx = x_q & (x_q - CW'(1));
  assign ny = y_q & (y_q - CW'(1));
  assign nz = z_q & (z_q - CW'(1));

  // Update walk: add the lowest set bit.
  assign ax = ux_q + (ux_q & (~ux_q + WW'(1)));
  assign ay = uy_q + (uy_q & (~uy_q + WW'(1)));
  assign az = uz_q + (uz_q & (~uz_q + WW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fw3_pkg::S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    lo_x_q  <= lo_x_d;
    lo_y_q  <= lo_y_d;
    lo_z_q  <= lo_z_d;
    hi_x_q  <= hi_x_d;
    hi_y_q  <= hi_y_d;
    hi_z_q  <= hi_z_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    ux_q    <= ux_d;
    uy_q    <= uy_d;
    uz_q    <= uz_d;
    k_q     <= k_d;
    acc_q   <= acc_d;
    delta_q <= delta_d;
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_d   = cmd_q;
    lo_x_d  = lo_x_q;
    lo_y_d  = lo_y_q;
    lo_z_d  = lo_z_q;
    hi_x_d  = hi_x_q;
    hi_y_d  = hi_y_q;
    hi_z_d  = hi_z_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    ux_d    = ux_q;
    uy_d    = uy_q;
    uz_d    = uz_q;
    k_d     = k_q;
    acc_d   = acc_q;
    delta_d = delta_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_data_o  = acc_q;
    ram_req_o   = '0;
    alu_req_o.sub = 1'b0;
    alu_req_o.a   = acc_q;
    alu_req_o.b   = '0;

    unique case (state_q)
      fw3_pkg::S_CLEAR: begin
        ram_req_o.we   = 1'b1;
        ram_req_o.addr = clr_q;
        clr_d = clr_q + fw3_pkg::ADDR_W'(1);
        if (&clr_q) begin
          state_d = fw3_pkg::S_IDLE;
        end
      end
      fw3_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d  = cmd_i;
          lo_x_d = low_x_i;
          lo_y_d = low_y_i;
          lo_z_d = low_z_i;
          // A mark reads its own cell as a one-cell box.
          hi_x_d = (cmd_i == fw3_pkg::CMD_COUNT) ? high_x_i : low_x_i;
          hi_y_d = (cmd_i == fw3_pkg::CMD_COUNT) ? high_y_i : low_y_i;
          hi_z_d = (cmd_i == fw3_pkg::CMD_COUNT) ? high_z_i : low_z_i;
          acc_d  = '0;
          k_d    = '0;
          // Drop a mark outside the grid right here.
          if (cmd_i == fw3_pkg::CMD_COUNT || mark_ok) begin
            state_d = fw3_pkg::S_PSETUP;
          end
        end
      end
      fw3_pkg::S_PSETUP: begin
        cx_d = px;
        cy_d = py;
        cz_d = pz;
        x_d  = px;
        y_d  = py;
        z_d  = pz;
        if (px != '0 && py != '0 && pz != '0) begin
          state_d = fw3_pkg::S_PREAD;
        end else if (last_k) begin
          state_d = (cmd_q == fw3_pkg::CMD_MARK) ? fw3_pkg::S_DELTA : fw3_pkg::S_DONE;
        end else begin
          k_d = k_q + fw3_pkg::PFX_W'(1);
        end
      end
      fw3_pkg::S_PREAD: begin
        ram_req_o.re   = 1'b1;
        ram_req_o.addr = node_addr(x_q, y_q, z_q);
        state_d = fw3_pkg::S_PACC;
      end
      fw3_pkg::S_PACC: begin
        alu_req_o.sub = ^k_q;
        alu_req_o.a   = acc_q;
        alu_req_o.b   = sext(ram_rdata_i);
        acc_d   = alu_res_i;
        state_d = fw3_pkg::S_PREAD;
        if (nz != '0) begin
          z_d = nz;
        end else begin
          z_d = cz_q;
          if (ny != '0) begin
            y_d = ny;
          end else begin
            y_d = cy_q;
            if (nx != '0) begin
              x_d = nx;
            end else if (last_k) begin
              state_d = (cmd_q == fw3_pkg::CMD_MARK) ? fw3_pkg::S_DELTA : fw3_pkg::S_DONE;
            end else begin
              k_d     = k_q + fw3_pkg::PFX_W'(1);
              state_d = fw3_pkg::S_PSETUP;
            end
          end
        end
      end
      fw3_pkg::S_DELTA: begin
        alu_req_o.sub = 1'b1;
        alu_req_o.a   = fw3_pkg::OUT_W'(1);
        alu_req_o.b   = acc_q;
        delta_d = alu_res_i[fw3_pkg::NODE_W-1:0];
        ux_d    = WW'(lo_x_q);
        uy_d    = WW'(lo_y_q);
        uz_d    = WW'(lo_z_q);
        state_d = fw3_pkg::S_UREAD;
      end
      fw3_pkg::S_UREAD: begin
        ram_req_o.re   = 1'b1;
        ram_req_o.addr = node_addr(ux_q[CW-1:0], uy_q[CW-1:0], uz_q[CW-1:0]);
        state_d = fw3_pkg::S_UWRITE;
      end
      fw3_pkg::S_UWRITE: begin
        alu_req_o.sub   = 1'b0;
        alu_req_o.a     = sext(ram_rdata_i);
        alu_req_o.b     = sext(delta_q);
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = node_addr(ux_q[CW-1:0], uy_q[CW-1:0], uz_q[CW-1:0]);
        ram_req_o.wdata = alu_res_i[fw3_pkg::NODE_W-1:0];
        state_d = fw3_pkg::S_UREAD;
        if (az <= g_w) begin
          uz_d = az;
        end else begin
          uz_d = WW'(lo_z_q);
          if (ay <= g_w) begin
            uy_d = ay;
          end else begin
            uy_d = WW'(lo_y_q);
            if (ax <= g_w) begin
              ux_d = ax;
            end else begin
              state_d = fw3_pkg::S_IDLE;
            end
          end
        end
      end
      fw3_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_free_i) begin
          state_d = fw3_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fw3_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/fenwick_3d_mark_and_box_count.sv
// Three-dimensional Fenwick tree of 16x16x16 13-bit counters in one single-port RAM. After
// reset the block sweeps all 4096 entries to zero, one entry per cycle, with in_ready_o
// low; grid_size writes are taken during the sweep. A count command runs eight prefix
// walks; each walk has one setup step, then a read and an accumulate step per tree node
// visited, at most 4x4x4 nodes at grid size 16 (an axis coordinate of 15 visits four). A
// mark runs the same eight walks on its cell, a step to form the delta, then a
// read-modify-write walk with a read and a write step per node (up to 5x5x5 nodes). The
// single RAM port and the one shared adder serialise these steps. A mark outside the grid
// is accepted and dropped without a walk. A finished count waits in an output register, so
// the next command is taken while the result is still pending.
module fenwick_3d_mark_and_box_count (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fw3_pkg::COORD_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [fw3_pkg::COORD_W-1:0]        low_x_i,
  input  logic [fw3_pkg::COORD_W-1:0]        low_y_i,
  input  logic [fw3_pkg::COORD_W-1:0]        low_z_i,
  input  logic [fw3_pkg::COORD_W-1:0]        high_x_i,
  input  logic [fw3_pkg::COORD_W-1:0]        high_y_i,
  input  logic [fw3_pkg::COORD_W-1:0]        high_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [fw3_pkg::OUT_W-1:0]   box_count_o
);

  logic [fw3_pkg::COORD_W-1:0] grid_q;
  logic [fw3_pkg::COORD_W-1:0] grid_eff;
  logic                        out_valid_q;
  logic [fw3_pkg::OUT_W-1:0]   box_count_q;

  fw3_pkg::ram_req_t           ram_req;
  logic [fw3_pkg::NODE_W-1:0]  ram_rdata;
  fw3_pkg::alu_req_t           alu_req;
  logic [fw3_pkg::OUT_W-1:0]   alu_res;
  logic                        res_valid;
  logic [fw3_pkg::OUT_W-1:0]   res_data;
  logic                        res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= fw3_pkg::COORD_W'(fw3_pkg::GRID_RESET);
    end else if (cfg_we_i) begin
      grid_q <= cfg_data_i;
    end
  end

  // Saturate the grid size to the tree dimension.
  assign grid_eff = (grid_q > fw3_pkg::COORD_W'(fw3_pkg::GRID_MAX)) ?
                    fw3_pkg::COORD_W'(fw3_pkg::GRID_MAX) : grid_q;

  assign res_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      box_count_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign box_count_o = box_count_q;

  fw3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .low_x_i     (low_x_i),
    .low_y_i     (low_y_i),
    .low_z_i     (low_z_i),
    .high_x_i    (high_x_i),
    .high_y_i    (high_y_i),
    .high_z_i    (high_z_i),
    .grid_i      (grid_eff),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .alu_req_o   (alu_req),
    .alu_res_i   (alu_res),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .res_free_i  (res_free)
  );

  fw3_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  fw3_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

endmodule

>>> rtl/fw3_checker.sv
module fw3_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic [fw3_pkg::COORD_W-1:0]        cfg_data_i,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               cmd_i,
  input logic [fw3_pkg::COORD_W-1:0]        low_x_i,
  input logic [fw3_pkg::COORD_W-1:0]        low_y_i,
  input logic [fw3_pkg::COORD_W-1:0]        low_z_i,
  input logic [fw3_pkg::COORD_W-1:0]        high_x_i,
  input logic [fw3_pkg::COORD_W-1:0]        high_y_i,
  input logic [fw3_pkg::COORD_W-1:0]        high_z_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [fw3_pkg::OUT_W-1:0]   box_count_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(box_count_o))
    else $error("result changed while stalled");

  // An accepted count leaves the block busy in the following cycle.
  a_count_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == fw3_pkg::CMD_COUNT) |=> !in_ready_o)
    else $error("ready right after a count beat");

  // A new result only appears at the end of a busy stretch.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  // A mark never produces a result.
  a_mark_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == fw3_pkg::CMD_MARK) |=> !$rose(out_valid_o))
    else $error("result after a mark beat");

endmodule

bind fenwick_3d_mark_and_box_count fw3_checker u_fw3_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int MARK_DRAIN  = 2500;
  localparam int HOLD_CYCLES = 3000;
  localparam int QUIET_LIMIT = 40000;

  typedef struct packed {
    logic                        cmd;
    logic [fw3_pkg::COORD_W-1:0] low_x;
    logic [fw3_pkg::COORD_W-1:0] low_y;
    logic [fw3_pkg::COORD_W-1:0] low_z;
    logic [fw3_pkg::COORD_W-1:0] high_x;
    logic [fw3_pkg::COORD_W-1:0] high_y;
    logic [fw3_pkg::COORD_W-1:0] high_z;
  } box_cmd_t;

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             cfg_we_i    = 1'b0;
  logic [fw3_pkg::COORD_W-1:0]      cfg_data_i  = '0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_ready_o;
  logic                             cmd_i       = fw3_pkg::CMD_MARK;
  logic [fw3_pkg::COORD_W-1:0]      low_x_i     = '0;
  logic [fw3_pkg::COORD_W-1:0]      low_y_i     = '0;
  logic [fw3_pkg::COORD_W-1:0]      low_z_i     = '0;
  logic [fw3_pkg::COORD_W-1:0]      high_x_i    = '0;
  logic [fw3_pkg::COORD_W-1:0]      high_y_i    = '0;
  logic [fw3_pkg::COORD_W-1:0]      high_z_i    = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic signed [fw3_pkg::OUT_W-1:0] box_count_o;

  // shadow copy of the tree and the grid register
  logic [fw3_pkg::NODE_W-1:0]       tree_shadow [fw3_pkg::DEPTH] = '{default: '0};
  logic [fw3_pkg::COORD_W-1:0]      grid_shadow = fw3_pkg::COORD_W'(fw3_pkg::GRID_RESET);
  logic signed [fw3_pkg::OUT_W-1:0] count_q [$];
  logic signed [fw3_pkg::OUT_W-1:0] want_count;
  int                               mismatches  = 0;

  // sender pacing
  int   burst_left  = 0;
  logic steady_send = 1'b0;

  // receiver stall control
  int          hold_asks  = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  int          ready_mode = 0;
  int          mode_left  = 0;
  logic [11:0] stall_pat  = 12'b1101_1100_0110;

  fenwick_3d_mark_and_box_count dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .low_x_i     (low_x_i),
    .low_y_i     (low_y_i),
    .low_z_i     (low_z_i),
    .high_x_i    (high_x_i),
    .high_y_i    (high_y_i),
    .high_z_i    (high_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .box_count_o (box_count_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int grid_eff();
    return (grid_shadow > fw3_pkg::GRID_MAX) ? fw3_pkg::GRID_MAX : int'(grid_shadow);
  endfunction

  function automatic int clip_axis(int c, int g);
    if (c <= 0) return 0;
    return (c > g) ? g : c;
  endfunction

  function automatic int node_addr(int x, int y, int z);
    return ((x - 1) * fw3_pkg::GRID_MAX + (y - 1)) * fw3_pkg::GRID_MAX + (z - 1);
  endfunction

  function automatic int prefix_sum(int cx, int cy, int cz);
    int g, acc, y, z;
    g   = grid_eff();
    acc = 0;
    for (int x = clip_axis(cx, g); x > 0; x &= x - 1)
      for (y = clip_axis(cy, g); y > 0; y &= y - 1)
        for (z = clip_axis(cz, g); z > 0; z &= z - 1)
          acc += $signed(tree_shadow[node_addr(x, y, z)]);
    return acc;
  endfunction

  function automatic int box_total(int x1, int y1, int z1, int x2, int y2, int z2);
    return prefix_sum(x2, y2, z2)
         - prefix_sum(x1 - 1, y2, z2)
         - prefix_sum(x2, y1 - 1, z2)
         - prefix_sum(x2, y2, z1 - 1)
         + prefix_sum(x1 - 1, y1 - 1, z2)
         + prefix_sum(x1 - 1, y2, z1 - 1)
         + prefix_sum(x2, y1 - 1, z1 - 1)
         - prefix_sum(x1 - 1, y1 - 1, z1 - 1);
  endfunction

  // nodes wrap at NODE_W bits
  function automatic void tree_bump(int x0, int y0, int z0, int delta);
    int g, y, z;
    g = grid_eff();
    for (int x = x0; x <= g; x += x & -x)
      for (y = y0; y <= g; y += y & -y)
        for (z = z0; z <= g; z += z & -z)
          tree_shadow[node_addr(x, y, z)] += delta[fw3_pkg::NODE_W-1:0];
  endfunction

  function automatic void apply_beat(box_cmd_t b);
    int g, lx, ly, lz, cur;
    g  = grid_eff();
    lx = int'(b.low_x);
    ly = int'(b.low_y);
    lz = int'(b.low_z);
    if (b.cmd == fw3_pkg::CMD_COUNT) begin
      count_q.push_back(fw3_pkg::OUT_W'(box_total(lx, ly, lz, int'(b.high_x),
                                                  int'(b.high_y), int'(b.high_z))));
    end else if (lx >= 1 && ly >= 1 && lz >= 1 && lx <= g && ly <= g && lz <= g) begin
      // force the cell to exactly one
      cur = box_total(lx, ly, lz, lx, ly, lz);
      tree_bump(lx, ly, lz, 1 - cur);
    end
  endfunction

  function automatic box_cmd_t rand_beat(int g);
    box_cmd_t b;
    int span, t;
    int lo[3], hi[3];
    span  = (g < 1) ? fw3_pkg::GRID_MAX : g;
    b.cmd = ($urandom_range(0, 99) < 55) ? fw3_pkg::CMD_MARK : fw3_pkg::CMD_COUNT;
    if ($urandom_range(0, 9) == 0) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = $urandom_range(0, 31);
        hi[a] = $urandom_range(0, 31);
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = $urandom_range(1, span);
        hi[a] = $urandom_range(1, span);
        // mostly ordered corners, now and then an inverted axis
        if (lo[a] > hi[a] && $urandom_range(0, 7) != 0) begin
          t     = lo[a];
          lo[a] = hi[a];
          hi[a] = t;
        end
      end
    end
    b.low_x  = fw3_pkg::COORD_W'(lo[0]);
    b.low_y  = fw3_pkg::COORD_W'(lo[1]);
    b.low_z  = fw3_pkg::COORD_W'(lo[2]);
    b.high_x = fw3_pkg::COORD_W'(hi[0]);
    b.high_y = fw3_pkg::COORD_W'(hi[1]);
    b.high_z = fw3_pkg::COORD_W'(hi[2]);
    return b;
  endfunction

  task automatic issue_beat(box_cmd_t b);
    int gap;
    if (!steady_send && burst_left == 0) begin
      gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    cmd_i      <= b.cmd;
    low_x_i    <= b.low_x;
    low_y_i    <= b.low_y;
    low_z_i    <= b.low_z;
    high_x_i   <= b.high_x;
    high_y_i   <= b.high_y;
    high_z_i   <= b.high_z;
    do @(posedge clk_i); while (!in_ready_o);
    apply_beat(b);
  endtask

  task automatic mark_cell(int x, int y, int z);
    issue_beat('{fw3_pkg::CMD_MARK, fw3_pkg::COORD_W'(x), fw3_pkg::COORD_W'(y),
                 fw3_pkg::COORD_W'(z), '0, '0, '0});
  endtask

  task automatic count_box(int x1, int y1, int z1, int x2, int y2, int z2);
    issue_beat('{fw3_pkg::CMD_COUNT, fw3_pkg::COORD_W'(x1), fw3_pkg::COORD_W'(y1),
                 fw3_pkg::COORD_W'(z1), fw3_pkg::COORD_W'(x2), fw3_pkg::COORD_W'(y2),
                 fw3_pkg::COORD_W'(z2)});
  endtask

  // drain all counts, then give a trailing mark time to finish its walks
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (count_q.size() != 0) @(posedge clk_i);
    repeat (MARK_DRAIN) @(posedge clk_i);
  endtask

  task automatic write_grid(logic [fw3_pkg::COORD_W-1:0] size);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= size;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    grid_shadow = size;
  endtask

  task automatic test_directed_cells();
    count_box(1, 1, 1, 16, 16, 16);
    mark_cell(1, 1, 1);
    mark_cell(16, 16, 16);
    mark_cell(16, 1, 8);
    mark_cell(1, 1, 1);
    mark_cell(0, 5, 5);
    mark_cell(17, 2, 2);
    mark_cell(31, 31, 31);
    count_box(1, 1, 1, 16, 16, 16);
    count_box(16, 16, 16, 1, 1, 1);
    count_box(0, 0, 0, 31, 31, 31);
    count_box(16, 16, 16, 16, 16, 16);
    count_box(5, 5, 5, 4, 4, 4);
    count_box(16, 1, 8, 16, 1, 8);
    settle();
  endtask

  task automatic test_grid_extremes();
    write_grid(5'd0);
    mark_cell(2, 2, 2);
    count_box(1, 1, 1, 16, 16, 16);
    settle();
    write_grid(5'd31);
    count_box(1, 1, 1, 31, 31, 31);
    mark_cell(16, 16, 16);
    settle();
    write_grid(5'd1);
    mark_cell(1, 1, 1);
    mark_cell(2, 1, 1);
    count_box(0, 0, 0, 31, 31, 31);
    settle();
    // shrink over existing marks: cells may no longer read as 0 or 1
    write_grid(5'd3);
    mark_cell(3, 3, 3);
    mark_cell(2, 3, 1);
    count_box(1, 1, 1, 3, 3, 3);
    count_box(3, 3, 3, 1, 1, 1);
    settle();
    write_grid(5'd16);
    count_box(1, 1, 1, 16, 16, 16);
    settle();
  endtask

  task automatic test_output_backpressure();
    box_cmd_t b;
    hold_asks++;
    steady_send = 1'b1;
    for (int n = 0; n < 12; n++) begin
      b     = rand_beat(grid_eff());
      b.cmd = fw3_pkg::CMD_COUNT;
      issue_beat(b);
    end
    steady_send = 1'b0;
    settle();
  endtask

  task automatic test_random_phases();
    logic [fw3_pkg::COORD_W-1:0] sizes [8] = '{5'd16, 5'd4, 5'd1, 5'd31,
                                               5'd9, 5'd0, 5'd16, 5'd12};
    for (int p = 0; p < 8; p++) begin
      write_grid(sizes[p]);
      steady_send = (p % 3 == 1);
      for (int n = 0; n < 72; n++) issue_beat(rand_beat(grid_eff()));
      steady_send = 1'b0;
      settle();
    end
  endtask

  // receiver: own stall pattern, random modes, and one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    stall_pat = {stall_pat[10:0], stall_pat[11]};
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (ready_mode)
        0: begin
          out_ready_i <= 1'b1;
        end
        1: begin
          out_ready_i <= stall_pat[0];
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (count_q.size() == 0) begin
        $display("%0t: box_count expected none, actual %0d", $time, box_count_o);
        mismatches++;
      end else begin
        want_count = count_q.pop_front();
        if (box_count_o !== want_count) begin
          $display("%0t: box_count expected %0d, actual %0d", $time, want_count, box_count_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_grid(5'd16);
    test_directed_cells();
    test_grid_extremes();
    test_output_backpressure();
    test_random_phases();
    if (mismatches == 0 && count_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
